### sv/int_to_ascii_radix_core_defines.svh
// Assertion macros for the integer to ASCII conversion core.
`ifndef INT_TO_ASCII_RADIX_CORE_DEFINES_SVH
`define INT_TO_ASCII_RADIX_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, disabled while in reset.
`define ITAR_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, disabled while in reset.
`define ITAR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/itar_pkg.sv
// Package: shared constants, types and helpers of the integer to ASCII core.
`timescale 1ns / 1ps
package itar_pkg;

	localparam int VALUE_WIDTH = 32;
	localparam int MAX_DIGITS  = 32;

	// Divider: STEP_BITS quotient bits per cycle, dividend padded to whole steps
	localparam int STEP_BITS = 8;
	localparam int DIV_STEPS = (VALUE_WIDTH + STEP_BITS - 1) / STEP_BITS;
	localparam int DIV_WIDTH = DIV_STEPS * STEP_BITS;
	localparam int STEP_W    = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

	localparam int ADDR_W  = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
	localparam int COUNT_W = $clog2(MAX_DIGITS + 1);

	localparam int RADIX_W  = 6;
	localparam int DIGIT_W  = 6;
	localparam int CHAR_W   = 7;

	localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
	localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
	localparam logic [RADIX_W-1:0] RADIX_DEC   = 6'd10;

	localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 7'h30;
	localparam logic [CHAR_W-1:0]  CHAR_A     = 7'h61;
	localparam logic [CHAR_W-1:0]  CHAR_MINUS = 7'h2d;
	localparam logic [DIGIT_W-1:0] DIGIT_TEN  = 6'hA;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_SIGN,
		ST_READ,
		ST_EMIT
	} itar_state_t;

	typedef struct packed {
		logic load;
		logic div_step;
		logic rd;
		logic sign_sel;
	} itar_cmd_t;

	typedef struct packed {
		logic div_last;
		logic conv_done;
		logic minus;
		logic emit_last;
	} itar_sts_t;

	function automatic logic [CHAR_W-1:0] char_of_digit(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] c;
		if (d < DIGIT_TEN) begin
			c = CHAR_ZERO + CHAR_W'(d);
		end else begin
			c = CHAR_A + CHAR_W'(d - DIGIT_TEN);
		end
		return c;
	endfunction

endpackage

### sv/itar_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module itar_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

### sv/itar_datapath.sv
// Datapath: radix register, iterative divider, digit store and character output.
`timescale 1ns / 1ps
module itar_datapath (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   radix_we,
	input  logic [itar_pkg::RADIX_W-1:0]           radix_wdata,
	input  logic [itar_pkg::VALUE_WIDTH-1:0]       value,
	input  itar_pkg::itar_cmd_t                    cmd,
	output itar_pkg::itar_sts_t                    sts,
	output logic [itar_pkg::CHAR_W-1:0]            char_code,
	output logic                                   last_char
);
	import itar_pkg::*;

	logic [RADIX_W-1:0]   radix_q;
	logic [DIV_WIDTH-1:0] quo_q;
	logic [DIGIT_W-1:0]   rem_q;
	logic [STEP_W-1:0]    step_q;
	logic [COUNT_W-1:0]   cnt_q;
	logic                 minus_q;
	logic                 last_q;

	logic [DIV_WIDTH-1:0]   quo_n;
	logic [DIGIT_W-1:0]     rem_n;
	logic                   div_last;
	logic                   neg_dec;
	logic [VALUE_WIDTH-1:0] mag;
	logic [COUNT_W-1:0]     cnt_dec;
	logic [DIGIT_W-1:0]     rd_digit;

	// Clamp writes into the legal radix range
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= RADIX_RESET;
		end else if (radix_we) begin
			if (radix_wdata < RADIX_MIN) begin
				radix_q <= RADIX_MIN;
			end else if (radix_wdata > RADIX_MAX) begin
				radix_q <= RADIX_MAX;
			end else begin
				radix_q <= radix_wdata;
			end
		end
	end

	assign neg_dec = value[VALUE_WIDTH-1] && (radix_q == RADIX_DEC);
	assign mag     = neg_dec ? (~value + VALUE_WIDTH'(1)) : value;

	// Restoring division, STEP_BITS quotient bits per cycle, MSB first
	always_comb begin
		logic [DIGIT_W:0]     r7;
		logic [DIV_WIDTH-1:0] q;
		logic [DIGIT_W-1:0]   r;
		q = quo_q;
		r = rem_q;
		for (int k = 0; k < STEP_BITS; k++) begin
			r7 = {r, q[DIV_WIDTH-1]};
			q  = {q[DIV_WIDTH-2:0], 1'b0};
			if (r7 >= {1'b0, radix_q}) begin
				r7   = r7 - {1'b0, radix_q};
				q[0] = 1'b1;
			end
			r = r7[DIGIT_W-1:0];
		end
		quo_n = q;
		rem_n = r;
	end

	assign div_last = (step_q == STEP_W'(DIV_STEPS - 1));
	assign cnt_dec  = cnt_q - COUNT_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quo_q   <= '0;
			rem_q   <= '0;
			step_q  <= '0;
			cnt_q   <= '0;
			minus_q <= 1'b0;
			last_q  <= 1'b0;
		end else if (cmd.load) begin
			quo_q   <= DIV_WIDTH'(mag);
			rem_q   <= '0;
			step_q  <= '0;
			cnt_q   <= '0;
			minus_q <= neg_dec;
		end else if (cmd.div_step) begin
			quo_q <= quo_n;
			if (div_last) begin
				rem_q  <= '0;
				step_q <= '0;
				cnt_q  <= cnt_q + COUNT_W'(1);
			end else begin
				rem_q  <= rem_n;
				step_q <= step_q + STEP_W'(1);
			end
		end else if (cmd.rd) begin
			cnt_q  <= cnt_dec;
			last_q <= (cnt_q == COUNT_W'(1));
		end
	end

	itar_ram #(
		.WIDTH (DIGIT_W),
		.DEPTH (MAX_DIGITS)
	) u_digits (
		.clk   (clk),
		.we    (cmd.div_step && div_last),
		.waddr (cnt_q[ADDR_W-1:0]),
		.wdata (rem_n),
		.re    (cmd.rd),
		.raddr (cnt_dec[ADDR_W-1:0]),
		.rdata (rd_digit)
	);

	assign sts.div_last  = div_last;
	assign sts.conv_done = (quo_n == '0) || (cnt_q == COUNT_W'(MAX_DIGITS - 1));
	assign sts.minus     = minus_q;
	assign sts.emit_last = last_q;

	assign char_code = cmd.sign_sel ? CHAR_MINUS : char_of_digit(rd_digit);
	assign last_char = cmd.sign_sel ? 1'b0 : last_q;
endmodule

### sv/itar_ctrl.sv
// Controller: state machine sequencing load, division, sign and character output.
`timescale 1ns / 1ps
module itar_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  itar_pkg::itar_sts_t sts,
	output itar_pkg::itar_cmd_t cmd
);
	import itar_pkg::*;

	itar_state_t state_q;
	itar_state_t state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_n = ST_DIV;
			end
			ST_DIV: begin
				if (sts.div_last && sts.conv_done) state_n = sts.minus ? ST_SIGN : ST_READ;
			end
			ST_SIGN: begin
				if (out_ready) state_n = ST_READ;
			end
			ST_READ: begin
				state_n = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_ready) state_n = sts.emit_last ? ST_IDLE : ST_READ;
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
			end
			ST_SIGN: begin
				cmd.sign_sel = 1'b1;
				out_valid    = 1'b1;
			end
			ST_READ: begin
				cmd.rd = 1'b1;
			end
			ST_EMIT: begin
				out_valid = 1'b1;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end
endmodule

### sv/int_to_ascii_radix_core.sv
// Top level: integer to ASCII text conversion in a configurable radix.
// Each item takes a load, a division pass per digit in the shared divider, an optional
// sign character and a digit store read and emit per digit character.
// Radix 10 worst case is ten digits and a sign; radix 2 worst case is 32 digits.
// Digit characters leave from the digit store read register; output stalls stretch the item.
// arst_n clears the controller and counters at once and sets the radix to 10.
`timescale 1ns / 1ps
`include "int_to_ascii_radix_core_defines.svh"
module int_to_ascii_radix_core (
	input  logic                             clk,
	input  logic                             arst_n,
	// Radix register write, clamped to 2..36
	input  logic                             radix_we,
	input  logic [itar_pkg::RADIX_W-1:0]     radix_wdata,
	// Input stream: one integer per item, signed in radix 10 only
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [itar_pkg::VALUE_WIDTH-1:0] s_axis_tdata,   // [31:0] value
	// Output stream: one character per transfer, tlast on the item's final character
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [7:0]                       m_axis_tdata,   // [6:0] char_code, [7] zero
	output logic                             m_axis_tlast    // last_char
);
	import itar_pkg::*;

	itar_cmd_t          cmd;
	itar_sts_t          sts;
	logic [CHAR_W-1:0]  char_code;
	logic               in_take;
	logic               last_take;
	logic               char_legal;

	// Controller: accept a value only when idle, then sequence divide and emit
	itar_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Datapath: magnitude, digit-by-digit division, digit store, character map
	itar_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.radix_we    (radix_we),
		.radix_wdata (radix_wdata),
		.value       (s_axis_tdata),
		.cmd         (cmd),
		.sts         (sts),
		.char_code   (char_code),
		.last_char   (m_axis_tlast)
	);

	// Pad the 7-bit character to a whole byte
	assign m_axis_tdata = {1'b0, char_code};

	assign in_take    = s_axis_tvalid && s_axis_tready;
	assign last_take  = m_axis_tvalid && m_axis_tready && m_axis_tlast;
	assign char_legal = (char_code == CHAR_MINUS)
		|| ((char_code >= CHAR_ZERO) && (char_code <= 7'h39))
		|| ((char_code >= CHAR_A) && (char_code <= 7'h7a));

	// Never accept a new value while a character is on offer
	`ITAR_ASSERT_NOW(a_no_overlap, in_take, !m_axis_tvalid, "input accepted during output")
	// Drop ready once a value has been taken
	`ITAR_ASSERT_NEXT(a_busy_after_load, in_take, !s_axis_tready, "ready held after load")
	// Return to idle after the final character
	`ITAR_ASSERT_NEXT(a_idle_after_last, last_take, s_axis_tready, "not idle after last character")
	// Only minus, decimal digits or lower-case letters leave the block
	`ITAR_ASSERT_NOW(a_char_legal, m_axis_tvalid, char_legal, "illegal character code")
endmodule
